@@ rtl/resol_pkg.sv @@
// Shared types and constants for the ring entry store with offset lookup.
`default_nettype none

package resol_pkg;

  // Ring size and stored byte-size width
  localparam int DEPTH     = 16;
  localparam int SIZE_BITS = 20;

  // Fixed field widths
  localparam int HANDLE_W  = 32;
  localparam int SIZE_IN_W = 20;
  localparam int POS_W     = 24;
  localparam int OFFSET_W  = 20;

  // Derived widths
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((POS_W > SIZE_BITS) ? POS_W : SIZE_BITS) + 1;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [HANDLE_W-1:0]  handle_in;
    logic [SIZE_IN_W-1:0] size_in;
    logic [POS_W-1:0]     byte_position;
  } in_word_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic [OFFSET_W-1:0] offset_out;
  } out_word_t;

  // One stored ring entry
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  // Control from the sequencer to the walk unit
  typedef struct packed {
    logic             start;
    logic             step;
    logic             in_range;
    logic [POS_W-1:0] pos;
  } walk_ctl_t;

  // Result held by the walk unit
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [OFFSET_W-1:0] offset;
  } walk_res_t;

endpackage

`default_nettype wire

@@ rtl/resol_cell.sv @@
// One cell of the entry chain: holds an entry and takes its neighbor's on a shift.
`default_nettype none

module resol_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire resol_pkg::entry_t d_in,
  output resol_pkg::entry_t    q,
  output logic                 usable
);
  import resol_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Take the neighbor's entry on a shift, hold otherwise
  always_comb begin
    entry_nxt = shift_en ? d_in : entry_r;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

  // Skip entries with a null handle or zero size
  assign usable = (entry_r.handle != '0) && (entry_r.size != '0);

endmodule

`default_nettype wire

@@ rtl/resol_walk.sv @@
// Running byte total and match capture for a find walk over the chain head.
`default_nettype none

module resol_walk (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire resol_pkg::walk_ctl_t ctl,
  input  wire resol_pkg::entry_t    head,
  input  wire logic                 head_usable,
  output resol_pkg::walk_res_t      res
);
  import resol_pkg::*;

  logic [POS_W-1:0] pos_r,     pos_nxt;
  logic [POS_W-1:0] running_r, running_nxt;
  walk_res_t        res_r,     res_nxt;
  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(running_r) + SUM_W'(head.size);

  // Clear on start, then test one head entry per step
  always_comb begin
    pos_nxt     = pos_r;
    running_nxt = running_r;
    res_nxt     = res_r;
    if (ctl.start) begin
      pos_nxt     = ctl.pos;
      running_nxt = '0;
      res_nxt     = '0;
    end else if (ctl.step && ctl.in_range && head_usable && !res_r.hit) begin
      if (SUM_W'(pos_r) < sum) begin
        res_nxt.hit    = 1'b1;
        res_nxt.handle = head.handle;
        res_nxt.offset = OFFSET_W'(pos_r - running_r);
      end else begin
        running_nxt = POS_W'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.hit <= 1'b0;
    end else begin
      res_r.hit <= res_nxt.hit;
    end
    res_r.handle <= res_nxt.handle;
    res_r.offset <= res_nxt.offset;
    pos_r        <= pos_nxt;
    running_r    <= running_nxt;
  end

  assign res = res_r;

  // Running total never passes the searched position
  a_running_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && !ctl.start) |=> (running_r <= pos_r))
    else $error("running total passed the searched position");

endmodule

`default_nettype wire

@@ rtl/ring_entry_store_offset_lookup_top.sv @@
// Top level: chain of entry cells, add/find sequencer and output register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_word  (operation, handle, size, position)
//  out_    | output    | out_valid/out_ready| out_word (hit, handle, offset)
//
// An add shifts the chain and loads its result into the output register in the same cycle.
// A find rotates the chain once through its DEPTH cells while the walk unit tests
// the head cell, then the result loads the output register.
// Reset (rst_n low, synchronous) empties the ring; cell contents are not cleared.
// A pending result that is not taken holds the block in its final find state and
// blocks new words until the output register frees.
`default_nettype none

module ring_entry_store_offset_lookup_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire resol_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output resol_pkg::out_word_t      out_word
);
  import resol_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r,   state_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [IDX_W-1:0] step_r,    step_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r,  out_word_nxt;

  entry_t           cell_q   [DEPTH];
  entry_t           cell_d   [DEPTH];
  logic             cell_use [DEPTH];

  logic             in_fire, add_fire, find_fire, out_free, shift_en, ring_full;
  entry_t           new_entry;
  walk_ctl_t        wctl;
  walk_res_t        wres;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign add_fire  = in_fire && (in_word.operation == OP_ADD);
  assign find_fire = in_fire && (in_word.operation == OP_FIND);
  assign ring_full = (count_r == CNT_W'(DEPTH));
  assign shift_en  = add_fire || (state_r == ST_WALK);

  assign new_entry.handle = in_word.handle_in;
  assign new_entry.size   = SIZE_BITS'(in_word.size_in);

  // Feed each cell from its right neighbor; the tail takes a new entry or the head
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      cell_d[i] = cell_q[i+1];
    end
    cell_d[DEPTH-1] = add_fire ? new_entry : cell_q[0];
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      resol_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_d[g]),
        .q        (cell_q[g]),
        .usable   (cell_use[g])
      );
    end
  endgenerate

  // Walk control: stored entries sit in the top count cells of the chain
  always_comb begin
    wctl.start    = find_fire;
    wctl.step     = (state_r == ST_WALK);
    wctl.in_range = ((CNT_W + 1)'(step_r) + (CNT_W + 1)'(count_r))
                    >= (CNT_W + 1)'(DEPTH);
    wctl.pos      = in_word.byte_position;
  end

  resol_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (wctl),
    .head        (cell_q[0]),
    .head_usable (cell_use[0]),
    .res         (wres)
  );

  // Sequencer, fill count and output register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (add_fire) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.hit        = ring_full;
          out_word_nxt.handle_out = ring_full ? cell_q[0].handle : '0;
          out_word_nxt.offset_out = '0;
          if (!ring_full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (find_fire) begin
          step_nxt  = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        step_nxt = step_r + IDX_W'(1);
        if (step_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.hit        = wres.hit;
          out_word_nxt.handle_out = wres.hit ? wres.handle : '0;
          out_word_nxt.offset_out = wres.hit ? wres.offset : '0;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Fill count stays within the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds ring depth");

  // No new word is taken while a find walks the chain
  a_no_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input accepted during a find");

  // A full ring stays full across an add
  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (add_fire && ring_full) |=> ring_full)
    else $error("full ring lost its full state");

  // A find walk always ends in the done state after a full rotation
  a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && step_r == IDX_W'(DEPTH - 1)) |=> (state_r == ST_DONE))
    else $error("find walk did not end after one rotation");

endmodule

`default_nettype wire

@@ tb/ring_lookup_checker.sv @@
// Checker for the ring entry store: predicts every result word and compares the output channel.
`timescale 1ns / 100ps

module ring_lookup_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  resol_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  resol_pkg::out_word_t out_word,
  output int                   fail_count,
  output int                   pending_count,
  output int                   add_count,
  output int                   overwrite_count,
  output int                   find_count,
  output int                   located_count
);
  import resol_pkg::*;

  // Running byte total is wide enough to sum DEPTH full-size entries
  localparam int TOTAL_W = SUM_W + IDX_W + 1;

  // Predicted ring contents and pointers
  logic [HANDLE_W-1:0]  entry_handle [DEPTH];
  logic [SIZE_BITS-1:0] entry_size   [DEPTH];
  logic [IDX_W-1:0]     wr_slot;
  logic [IDX_W-1:0]     oldest_slot;
  logic                 ring_is_full;

  // Result words still owed by the block, oldest first
  out_word_t expected_results [$];

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] slot);
    return (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // Apply one input word to the predicted ring and return the result word it causes
  function automatic out_word_t predict_lookup(in_word_t w);
    out_word_t          res;
    logic [IDX_W-1:0]   slot;
    logic [TOTAL_W-1:0] bytes_before;
    logic [TOTAL_W-1:0] pos;
    int                 live;
    res = '0;
    if (w.operation == OP_ADD) begin
      // report the victim and advance the oldest pointer when full
      if (ring_is_full) begin
        res.hit        = 1'b1;
        res.handle_out = entry_handle[wr_slot];
        oldest_slot    = next_slot(oldest_slot);
      end
      entry_handle[wr_slot] = w.handle_in;
      entry_size[wr_slot]   = SIZE_BITS'(w.size_in);
      wr_slot = next_slot(wr_slot);
      if (wr_slot == oldest_slot) ring_is_full = 1'b1;
    end else begin
      // walk oldest to newest, skipping null handles and empty entries
      live         = ring_is_full ? DEPTH : int'(wr_slot);
      slot         = oldest_slot;
      bytes_before = '0;
      pos          = TOTAL_W'(w.byte_position);
      for (int k = 0; k < live; k++) begin
        if (entry_handle[slot] != '0 && entry_size[slot] != '0) begin
          if (pos < bytes_before + TOTAL_W'(entry_size[slot])) begin
            res.hit        = 1'b1;
            res.handle_out = entry_handle[slot];
            res.offset_out = OFFSET_W'(pos - bytes_before);
            break;
          end
          bytes_before = bytes_before + TOTAL_W'(entry_size[slot]);
        end
        slot = next_slot(slot);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    out_word_t owed;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      wr_slot      = '0;
      oldest_slot  = '0;
      ring_is_full = 1'b0;
      expected_results.delete();
      fail_count      <= 0;
      add_count       <= 0;
      overwrite_count <= 0;
      find_count      <= 0;
      located_count   <= 0;
    end else begin
      // check each accepted result word against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: hit %0d handle_out %h offset_out %h",
                 out_word.hit, out_word.handle_out, out_word.offset_out);
          errs++;
        end else begin
          owed = expected_results.pop_front();
          if (out_word.hit !== owed.hit) begin
            $error("hit: expected %0d, actual %0d", owed.hit, out_word.hit);
            errs++;
          end
          if (out_word.handle_out !== owed.handle_out) begin
            $error("handle_out: expected %h, actual %h", owed.handle_out, out_word.handle_out);
            errs++;
          end
          if (out_word.offset_out !== owed.offset_out) begin
            $error("offset_out: expected %h, actual %h", owed.offset_out, out_word.offset_out);
            errs++;
          end
        end
      end
      // predict each accepted input word
      if (in_valid && in_ready) begin
        want = predict_lookup(in_word);
        expected_results.push_back(want);
        if (in_word.operation == OP_ADD) begin
          add_count       <= add_count + 1;
          overwrite_count <= overwrite_count + int'(want.hit);
        end else begin
          find_count    <= find_count + 1;
          located_count <= located_count + int'(want.hit);
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_results.size();
  end

endmodule

@@ tb/ring_entry_store_offset_lookup_top_test.sv @@
// Testbench top for the ring entry store: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module ring_entry_store_offset_lookup_top_test;
  import resol_pkg::*;

  localparam int RANDOM_WORDS   = 1025;
  localparam int HOLD_AT_WORD   = 300;
  localparam int DRAIN_AT_WORD  = 650;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 2 * DEPTH + 8;
  // Longest quiet stretch: receiver hold-off plus a find walk and sender gap, with margin
  localparam int IDLE_LIMIT     = 4000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  int fail_count;
  int pending_count;
  int add_count;
  int overwrite_count;
  int find_count;
  int located_count;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit rx_hold_req = 1'b0;

  ring_entry_store_offset_lookup_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  ring_lookup_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .add_count       (add_count),
    .overwrite_count (overwrite_count),
    .find_count      (find_count),
    .located_count   (located_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[ring_entry_store_offset_lookup_top] ERROR");
      $finish;
    end
  end

  // Stall the result channel: random ready density per stretch, long hold-off on request
  initial begin : rx_side
    int ready_pct;
    int stretch_left;
    out_ready    = 1'b0;
    ready_pct    = 100;
    stretch_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 50;
            default: ready_pct = 20;
          endcase
          stretch_left = $urandom_range(16, 96);
        end
        stretch_left--;
        out_ready = ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  function automatic in_word_t make_word(logic op, logic [HANDLE_W-1:0] handle,
                                         logic [SIZE_IN_W-1:0] size,
                                         logic [POS_W-1:0] pos);
    in_word_t w;
    w.operation     = op;
    w.handle_in     = handle;
    w.size_in       = size;
    w.byte_position = pos;
    return w;
  endfunction

  // Mix of adds and finds with null handles, empty and full-size entries, and edge offsets
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.operation = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_FIND;
    pick = $urandom_range(0, 9);
    if (pick == 0)      w.handle_in = '0;
    else if (pick == 1) w.handle_in = '1;
    else                w.handle_in = $urandom();
    pick = $urandom_range(0, 9);
    if (pick == 0)      w.size_in = '0;
    else if (pick == 1) w.size_in = '1;
    else if (pick < 6)  w.size_in = SIZE_IN_W'($urandom_range(1, 64));
    else                w.size_in = SIZE_IN_W'($urandom());
    pick = $urandom_range(0, 9);
    if (pick == 0)      w.byte_position = '0;
    else if (pick == 1) w.byte_position = '1;
    else if (pick < 5)  w.byte_position = POS_W'($urandom_range(0, 2047));
    else if (pick < 8)  w.byte_position = POS_W'($urandom_range(0, 1 << 22));
    else                w.byte_position = POS_W'($urandom());
    return w;
  endfunction

  // Offer one word; open a new burst after a random gap when the current one is used up
  task automatic push_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the input channel idle until every owed result word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty ring: find reports nothing
    push_word(make_word(OP_FIND, '0, '0, '0));
    // null handle, full-size entry, empty entry
    push_word(make_word(OP_ADD, '0, SIZE_IN_W'(5), '0));
    push_word(make_word(OP_ADD, '1, '1, '1));
    push_word(make_word(OP_ADD, HANDLE_W'(1), '0, '0));
    // first and last byte of the full-size entry, null entry skipped
    push_word(make_word(OP_FIND, '0, '0, '0));
    push_word(make_word(OP_FIND, '1, '1, POS_W'(20'hFFFFE)));
    push_word(make_word(OP_ADD, HANDLE_W'(32'hA5A5_5A5A), SIZE_IN_W'(1), '0));
    // empty entry skipped, then just past the total and the top offset
    push_word(make_word(OP_FIND, '0, '0, POS_W'(20'hFFFFF)));
    push_word(make_word(OP_FIND, '0, '0, POS_W'(24'h100000)));
    push_word(make_word(OP_FIND, '0, '0, '1));
    // fill the ring up to full
    for (int k = 0; k < DEPTH - 4; k++) begin
      push_word(make_word(OP_ADD, HANDLE_W'(k + 2), SIZE_IN_W'(k + 1), '0));
    end
    push_word(make_word(OP_FIND, '0, '0, '1));
    push_word(make_word(OP_FIND, '0, '0, POS_W'(24'h100004)));
    // overwrite the null handle, then the full-size entry
    push_word(make_word(OP_ADD, HANDLE_W'(32'h1234_5678), SIZE_IN_W'(3), '0));
    push_word(make_word(OP_ADD, HANDLE_W'(32'h8000_0001), SIZE_IN_W'(7), '0));

    // random traffic with one long receiver hold-off and one full drain
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == HOLD_AT_WORD) rx_hold_req = 1'b1;
      if (n == DRAIN_AT_WORD) wait_drained();
      push_word(random_word());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds (%0d overwrote the oldest entry) and %0d finds (%0d located).",
             add_count, overwrite_count, find_count, located_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ring_entry_store_offset_lookup_top] OK");
    end else begin
      $display("[ring_entry_store_offset_lookup_top] ERROR");
    end
    $finish;
  end

endmodule
